// ===== src/cct_pkg.sv =====
package cct_pkg;

    // Default configuration
    localparam int BIN_COUNT_DEF    = 30;
    localparam int CORDIC_STEPS_DEF = 16;

    // Fixed-point constants
    localparam int ATAB_LEN      = 24;
    localparam int INV_GAIN_Q16  = 39797;
    localparam int RADIUS_MIN_Q4 = 56;

    // Datapath widths
    localparam int CORD_W  = 22;   // CORDIC x/y, Q8 pixels, with gain headroom
    localparam int Z_W     = 18;   // angle, 65536 units per turn
    localparam int THETA_W = 17;   // non-negative angle from +y
    localparam int XMAG_W  = CORD_W - 1;
    localparam int GAIN_W  = 16;
    localparam int PROD_W  = XMAG_W + GAIN_W;
    localparam int DIST_W  = PROD_W - 20;
    localparam int TERM_W  = 18;
    localparam int ACC_W   = 32;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;

    localparam logic signed [Z_W-1:0] Z_HALF = 18'sd32768;

    typedef struct packed {
        logic [9:0]  point_x;
        logic [9:0]  point_y;
        logic [9:0]  center_x;
        logic [9:0]  center_y;
        logic [14:0] radius_q4;
        logic        last_point;
    } cct_in_t;

    typedef struct packed {
        logic             is_circle;
        logic             deviation_valid;
        logic [ACC_W-1:0] deviation_sum;
        logic             full_coverage;
    } cct_out_t;

    // Pre-rotated vector waiting for the CORDIC unit
    typedef struct packed {
        logic signed [10:0]    x0;
        logic signed [10:0]    y0;
        logic signed [Z_W-1:0] z0;
        logic [14:0]           radius_q4;
        logic                  last_point;
    } cct_work_t;

    typedef struct packed {
        logic      valid;
        cct_work_t data;
    } cct_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cct_qstat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ITER,
        S_MULT,
        S_DIST,
        S_ACCUM,
        S_VERDICT
    } cct_state_t;

    // Arctangent table, 65536 units per turn
    function automatic logic [13:0] atab(input logic [4:0] idx);
        logic [13:0] val;
        case (idx)
            5'd0:    val = 14'd8192;
            5'd1:    val = 14'd4836;
            5'd2:    val = 14'd2555;
            5'd3:    val = 14'd1297;
            5'd4:    val = 14'd651;
            5'd5:    val = 14'd326;
            5'd6:    val = 14'd163;
            5'd7:    val = 14'd81;
            5'd8:    val = 14'd41;
            5'd9:    val = 14'd20;
            5'd10:   val = 14'd10;
            5'd11:   val = 14'd5;
            5'd12:   val = 14'd3;
            5'd13:   val = 14'd1;
            5'd14:   val = 14'd1;
            default: val = 14'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== src/cct_front.sv =====
module cct_front (
    input  logic                s_valid,
    output logic                s_ready,
    input  cct_pkg::cct_in_t    s_data,
    input  cct_pkg::cct_qstat_t q_stat,
    output cct_pkg::cct_push_t  push
);

    logic signed [10:0] dx;
    logic signed [10:0] dy;
    logic               flip;

    // Offset from the center
    assign dx = $signed({1'b0, s_data.point_x}) - $signed({1'b0, s_data.center_x});
    assign dy = $signed({1'b0, s_data.point_y}) - $signed({1'b0, s_data.center_y});

    // Turn the vector a half turn when it points below the x axis
    assign flip = dy[10];

    assign s_ready = !q_stat.full;

    // Classify and push the item
    always_comb begin
        push.valid            = s_valid && !q_stat.full;
        push.data.x0          = flip ? -dy : dy;
        push.data.y0          = flip ? -dx : dx;
        push.data.z0          = !flip ? '0 : (dx[10] ? -cct_pkg::Z_HALF : cct_pkg::Z_HALF);
        push.data.radius_q4   = s_data.radius_q4;
        push.data.last_point  = s_data.last_point;
    end

endmodule

// ===== src/cct_queue.sv =====
module cct_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  cct_pkg::cct_push_t  push,
    input  logic                pop,
    output cct_pkg::cct_qstat_t q_stat,
    output cct_pkg::cct_work_t  head
);

    localparam int PTR_W = $clog2(cct_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(cct_pkg::QUEUE_DEPTH + 1);

    cct_pkg::cct_work_t item_reg [cct_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign q_stat.full  = (count_reg == CNT_W'(cct_pkg::QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head         = item_reg[rd_ptr_reg];

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push.valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push.valid, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Store the item
    always_ff @(posedge aclk) begin
        if (push.valid) begin
            item_reg[wr_ptr_reg] <= push.data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> !q_stat.full)
        else $error("item pushed into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("item popped from an empty queue");

endmodule

// ===== src/cct_back.sv =====
module cct_back #(
    parameter int BIN_COUNT    = cct_pkg::BIN_COUNT_DEF,
    parameter int CORDIC_STEPS = cct_pkg::CORDIC_STEPS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cct_pkg::cct_qstat_t q_stat,
    input  cct_pkg::cct_work_t  head,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output cct_pkg::cct_out_t   m_data
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam int BIN_W  = $clog2(BIN_COUNT);
    localparam int BP_W   = cct_pkg::THETA_W + $clog2(BIN_COUNT + 1);
    localparam int BR_W   = BP_W - 16;
    localparam int CW     = cct_pkg::CORD_W;
    localparam int ZW     = cct_pkg::Z_W;
    localparam int AW     = cct_pkg::ACC_W;

    cct_pkg::cct_state_t              state_reg, state_next;
    logic [STEP_W-1:0]                cnt_reg, cnt_next;
    logic signed [CW-1:0]             x_reg, x_next;
    logic signed [CW-1:0]             y_reg, y_next;
    logic signed [ZW-1:0]             z_reg, z_next;
    logic [14:0]                      r_reg, r_next;
    logic                             last_reg, last_next;
    logic [cct_pkg::PROD_W-1:0]       prod_reg, prod_next;
    logic [cct_pkg::TERM_W-1:0]       term_reg, term_next;
    logic [AW-1:0]                    acc_reg, acc_next;
    logic [BIN_COUNT-1:0]             bins_reg, bins_next;
    logic                             m_valid_reg, m_valid_next;
    cct_pkg::cct_out_t                m_data_reg, m_data_next;

    logic signed [CW-1:0]             xs, ys;
    logic signed [ZW-1:0]             ang;
    logic signed [ZW:0]               theta_s;
    logic [cct_pkg::THETA_W-1:0]      theta_u;
    logic [BP_W-1:0]                  bin_prod;
    logic [BR_W-1:0]                  bin_raw;
    logic [BIN_W-1:0]                 bin_idx;
    logic [cct_pkg::XMAG_W-1:0]       xmag;
    logic [cct_pkg::GAIN_W-1:0]       gain;
    logic [cct_pkg::PROD_W-1:0]       prod;
    logic [cct_pkg::PROD_W-1:0]       rounded;
    logic [cct_pkg::DIST_W-1:0]       dist_q4;
    logic [AW:0]                      sum_wide;
    logic [AW+2:0]                    s_x5;
    logic [AW+4:0]                    s_x25;
    logic                             loose, tight, big, bins_full, out_free;

    // CORDIC step: floor shifts and table angle
    assign xs  = x_reg >>> cnt_reg;
    assign ys  = y_reg >>> cnt_reg;
    assign ang = $signed({{(ZW - 14){1'b0}}, cct_pkg::atab(5'(cnt_reg))});

    // Angle from +y to bin index, clamp the full-turn case
    assign theta_s  = (ZW + 1)'(z_reg) + (ZW + 1)'(cct_pkg::Z_HALF);
    assign theta_u  = theta_s[ZW] ? '0 : theta_s[cct_pkg::THETA_W-1:0];
    assign bin_prod = BP_W'(theta_u) * BP_W'(BIN_COUNT);
    assign bin_raw  = bin_prod[BP_W-1:16];
    assign bin_idx  = (bin_raw >= BR_W'(BIN_COUNT - 1)) ? BIN_W'(BIN_COUNT - 1)
                                                         : BIN_W'(bin_raw);

    // Magnitude times inverse gain
    assign xmag = x_reg[CW-1] ? '0 : x_reg[cct_pkg::XMAG_W-1:0];
    assign gain = cct_pkg::GAIN_W'(cct_pkg::INV_GAIN_Q16);
    assign prod = xmag * gain;

    // Round the distance to Q4
    assign rounded = prod_reg + cct_pkg::PROD_W'(1 << 19);
    assign dist_q4 = rounded[cct_pkg::PROD_W-1:20];

    // Saturating sum
    assign sum_wide = {1'b0, acc_reg} + (AW + 1)'(term_reg);

    // Verdict tests
    assign s_x5      = (AW + 3)'(acc_reg) * (AW + 3)'(5);
    assign s_x25     = (AW + 5)'(acc_reg) * (AW + 5)'(25);
    assign loose     = s_x5  < ((AW + 3)'(r_reg) * (AW + 3)'(628));
    assign tight     = s_x25 < ((AW + 5)'(r_reg) * (AW + 5)'(1256));
    assign big       = r_reg > 15'(cct_pkg::RADIUS_MIN_Q4);
    assign bins_full = &bins_reg;

    assign out_free = !m_valid_reg || m_ready;

    // Sequence one point through the shared CORDIC unit
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        r_next       = r_reg;
        last_next    = last_reg;
        prod_next    = prod_reg;
        term_next    = term_reg;
        acc_next     = acc_reg;
        bins_next    = bins_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        pop          = 1'b0;

        case (state_reg)
            cct_pkg::S_IDLE: begin
                if (!q_stat.empty) begin
                    pop        = 1'b1;
                    x_next     = {{(CW - 19){head.x0[10]}}, head.x0, 8'b0};
                    y_next     = {{(CW - 19){head.y0[10]}}, head.y0, 8'b0};
                    z_next     = head.z0;
                    r_next     = head.radius_q4;
                    last_next  = head.last_point;
                    cnt_next   = '0;
                    state_next = cct_pkg::S_ITER;
                end
            end
            cct_pkg::S_ITER: begin
                if (!y_reg[CW-1]) begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + ang;
                end else begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - ang;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(CORDIC_STEPS - 1)) begin
                    state_next = cct_pkg::S_MULT;
                end
            end
            cct_pkg::S_MULT: begin
                prod_next          = prod;
                bins_next[bin_idx] = 1'b1;
                state_next         = cct_pkg::S_DIST;
            end
            cct_pkg::S_DIST: begin
                if (cct_pkg::TERM_W'(dist_q4) <= cct_pkg::TERM_W'(r_reg)) begin
                    term_next = cct_pkg::TERM_W'(r_reg) - cct_pkg::TERM_W'(dist_q4);
                end else begin
                    term_next = cct_pkg::TERM_W'(r_reg) + cct_pkg::TERM_W'(dist_q4);
                end
                state_next = cct_pkg::S_ACCUM;
            end
            cct_pkg::S_ACCUM: begin
                acc_next   = sum_wide[AW] ? '1 : sum_wide[AW-1:0];
                state_next = last_reg ? cct_pkg::S_VERDICT : cct_pkg::S_IDLE;
            end
            cct_pkg::S_VERDICT: begin
                if (out_free) begin
                    m_data_next.is_circle       = big && bins_full && loose && tight;
                    m_data_next.deviation_valid = loose;
                    m_data_next.deviation_sum   = acc_reg;
                    m_data_next.full_coverage   = bins_full;
                    m_valid_next                = 1'b1;
                    acc_next                    = '0;
                    bins_next                   = '0;
                    state_next                  = cct_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = cct_pkg::S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cct_pkg::S_IDLE;
            cnt_reg     <= '0;
            acc_reg     <= '0;
            bins_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            acc_reg     <= acc_next;
            bins_reg    <= bins_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold datapath
    always_ff @(posedge aclk) begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        r_reg      <= r_next;
        last_reg   <= last_next;
        prod_reg   <= prod_next;
        term_reg   <= term_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_verdict_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cct_pkg::S_VERDICT && out_free)
            |=> (acc_reg == '0 && bins_reg == '0 && m_valid_reg))
        else $error("verdict did not clear the contour state");

    a_result_from_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == cct_pkg::S_VERDICT)
        else $error("result raised outside the verdict step");

    a_full_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cct_pkg::S_MULT) |->
            ($past(state_reg) == cct_pkg::S_ITER
             && $past(cnt_reg) == STEP_W'(CORDIC_STEPS - 1)))
        else $error("CORDIC pass ended early");

    a_pop_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (state_reg == cct_pkg::S_ITER && cnt_reg == '0))
        else $error("popped item did not start a CORDIC pass");

endmodule

// ===== src/contour_circle_test.sv =====
// Circle test over one contour. Feed the contour's points one item each, with the
// same center and Q11.4 radius on every item and last_point set on the final one;
// a single verdict item follows the last point, and the angle bins and deviation
// sum then start over. For each point the back end loads it from the queue, then
// runs the CORDIC steps through the single shared vectoring unit, which sets the
// rate, then does the gain multiply, the distance rounding and the accumulate; it
// takes the next point only once the previous one is done. A last point adds a
// verdict step, which waits while the previous result item is not taken. A four-item
// queue behind the input lets points arrive in bursts, and the result sits in its
// own register so the next contour's points keep flowing while a verdict waits.
module contour_circle_test #(
    parameter int BIN_COUNT    = cct_pkg::BIN_COUNT_DEF,
    parameter int CORDIC_STEPS = cct_pkg::CORDIC_STEPS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cct_pkg::cct_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cct_pkg::cct_out_t m_data
);

    cct_pkg::cct_push_t  push;
    cct_pkg::cct_qstat_t q_stat;
    cct_pkg::cct_work_t  head;
    logic                pop;

    cct_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_stat  (q_stat),
        .push    (push)
    );

    cct_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .q_stat  (q_stat),
        .head    (head)
    );

    cct_back #(
        .BIN_COUNT    (BIN_COUNT),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_stat  (q_stat),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
